// ----- hw/rtl/i2c_master_byte_engine_assert.svh -----
// Assertion macros for the I2C master byte engine.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// Shared types and constants of the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int PRESCALE_WIDTH_DEF = 16;
    localparam int PHASE_TICKS_WIDTH = 16;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ----- hw/rtl/i2c_master_byte_engine.sv -----
// A request's result is valid in the cycle after the sequencer takes it from the queue.
// Throughput: one request per cycle while the output is not stalled; the sequencer steps its state once per request.
// A two-entry queue decouples the input from the sequencer and its result register.
// Synchronous active-low reset idles the sequencer, releases both lines and clears the
// received byte and acknowledge flag; the phase length returns to one tick.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_assert.svh"

module i2c_master_byte_engine #(
    parameter int PRESCALE_WIDTH = i2cm_pkg::PRESCALE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [i2cm_pkg::PHASE_TICKS_WIDTH-1:0] i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [2:0]                             i_command,
    input  logic [7:0]                             i_write_data,
    input  logic                                   i_send_ack,
    input  logic                                   i_sda_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_scl_low,
    output logic                                   o_sda_low,
    output logic                                   o_busy_res,
    output logic                                   o_done_res,
    output logic [7:0]                             o_read_data,
    output logic                                   o_ack_received
);

    i2cm_pkg::t_item     w_in_item;
    i2cm_pkg::t_item     w_q_item;
    i2cm_pkg::t_q_status w_q_status;
    logic                w_push;
    logic                w_pop;

    assign o_cfg_ready = 1'b1;

    i2cm_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_write_data (i_write_data),
        .i_send_ack   (i_send_ack),
        .i_sda_in     (i_sda_in),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_item       (w_in_item)
    );

    i2cm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_in_item),
        .i_pop    (w_pop),
        .o_item   (w_q_item),
        .o_status (w_q_status)
    );

    i2cm_back #(
        .PRESCALE_WIDTH (PRESCALE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_item         (w_q_item),
        .i_q_status     (w_q_status),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_scl_low      (o_scl_low),
        .o_sda_low      (o_sda_low),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_read_data    (o_read_data),
        .o_ack_received (o_ack_received)
    );

    `I2CM_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res)
    `I2CM_ASSERT_SAME(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_q_status.empty)
    `I2CM_ASSERT_NEXT(a_pop_gives_result, i_clk, i_rst_n, w_pop, o_out_valid)
    `I2CM_ASSERT_NEXT(a_push_fills_queue, i_clk, i_rst_n, w_push && !w_pop, !w_q_status.empty)

endmodule

// ----- hw/rtl/i2cm_front.sv -----
// Input side: accepts requests and decodes the command code.
`timescale 1ns / 1ps

module i2cm_front (
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_command,
    input  logic [7:0]          i_write_data,
    input  logic                i_send_ack,
    input  logic                i_sda_in,
    input  i2cm_pkg::t_q_status i_q_status,
    output logic                o_push,
    output i2cm_pkg::t_item     o_item
);

    i2cm_pkg::t_op w_op;

    // Unknown command codes are treated as no command.
    always_comb begin
        case (i_command)
            i2cm_pkg::OP_START: w_op = i2cm_pkg::OP_START;
            i2cm_pkg::OP_STOP:  w_op = i2cm_pkg::OP_STOP;
            i2cm_pkg::OP_WRITE: w_op = i2cm_pkg::OP_WRITE;
            i2cm_pkg::OP_READ:  w_op = i2cm_pkg::OP_READ;
            default:            w_op = i2cm_pkg::OP_IDLE;
        endcase
    end

    assign o_in_stall        = i_q_status.full;
    assign o_push            = i_in_valid && !i_q_status.full;
    assign o_item.op         = w_op;
    assign o_item.write_data = i_write_data;
    assign o_item.send_ack   = i_send_ack;
    assign o_item.sda_in     = i_sda_in;

endmodule

// ----- hw/rtl/i2cm_queue.sv -----
// Two-entry request queue between the input side and the sequencer.
`timescale 1ns / 1ps

module i2cm_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cm_pkg::t_item     i_item,
    input  logic                i_pop,
    output i2cm_pkg::t_item     o_item,
    output i2cm_pkg::t_q_status o_status
);

    i2cm_pkg::t_item r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    assign o_item          = r_mem[r_rptr];
    assign o_status.empty  = (r_count == 2'd0);
    assign o_status.full   = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/i2cm_back.sv -----
// Sequencer: runs the bus phases one request per cycle while the output is not stalled, and holds the result register.
`timescale 1ns / 1ps

module i2cm_back #(
    parameter int PRESCALE_WIDTH = i2cm_pkg::PRESCALE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [i2cm_pkg::PHASE_TICKS_WIDTH-1:0] i_cfg_data,
    input  i2cm_pkg::t_item                        i_item,
    input  i2cm_pkg::t_q_status                    i_q_status,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_scl_low,
    output logic                                   o_sda_low,
    output logic                                   o_busy_res,
    output logic                                   o_done_res,
    output logic [7:0]                             o_read_data,
    output logic                                   o_ack_received
);

    localparam int PTW = i2cm_pkg::PHASE_TICKS_WIDTH;
    localparam int CW  = (PRESCALE_WIDTH > PTW) ? PRESCALE_WIDTH : PTW;

    i2cm_pkg::t_op             r_op;
    logic [4:0]                r_phase;
    logic [PRESCALE_WIDTH-1:0] r_pre;
    logic [PRESCALE_WIDTH-1:0] r_limit;
    logic [7:0]                r_shift;
    logic                      r_scl;
    logic                      r_sda;
    logic                      r_ack;
    logic [7:0]                r_read_hold;
    logic                      r_ack_hold;

    i2cm_pkg::t_op             n_op;
    logic [4:0]                n_phase;
    logic [PRESCALE_WIDTH-1:0] n_pre;
    logic [7:0]                n_shift;
    logic                      n_scl;
    logic                      n_sda;
    logic                      n_ack;
    logic [7:0]                n_read_hold;
    logic                      n_ack_hold;
    logic                      n_done;

    logic [CW-1:0]             w_eff_m1;
    logic [CW-1:0]             w_cap_m1;
    logic [CW-1:0]             w_limit;
    logic [4:0]                w_phase_nx;

    function automatic logic [4:0] phase_total(input i2cm_pkg::t_op op);
        logic [4:0] t;
        case (op)
            i2cm_pkg::OP_START: t = 5'd3;
            i2cm_pkg::OP_STOP:  t = 5'd3;
            i2cm_pkg::OP_WRITE: t = 5'd26;
            i2cm_pkg::OP_READ:  t = 5'd20;
            default:            t = 5'd0;
        endcase
        return t;
    endfunction

    // Returns {scl, sda} drives on entry into a write-bit phase.
    function automatic logic [1:0] write_bit(input logic b, input logic [1:0] sub,
                                             input logic scl, input logic sda);
        logic [1:0] d;
        d = {scl, sda};
        case (sub)
            2'd0:    d = {1'b0, ~b};
            2'd1:    d = {1'b1, sda};
            default: d = {scl, sda | b};
        endcase
        return d;
    endfunction

    // Returns {scl, sda} drives on entry into phase p of operation op.
    function automatic logic [1:0] enter_phase(input i2cm_pkg::t_op op, input logic [4:0] p,
                                               input logic [7:0] sh, input logic ah,
                                               input logic scl, input logic sda);
        logic [1:0] d;
        logic [8:0] m;
        logic [2:0] q;
        logic [4:0] s;
        d = {scl, sda};
        m = {4'd0, p} * 9'd11;
        q = m[7:5];
        s = p - 5'(3 * q);
        case (op)
            i2cm_pkg::OP_START: begin
                if (p == 5'd0) begin
                    d = 2'b00;
                end else if (p == 5'd1) begin
                    d = {scl, 1'b1};
                end else begin
                    d = {1'b1, sda};
                end
            end
            i2cm_pkg::OP_STOP: begin
                if (p == 5'd0) begin
                    d = {scl, 1'b1};
                end else if (p == 5'd1) begin
                    d = {1'b0, sda};
                end else begin
                    d = {scl, 1'b0};
                end
            end
            i2cm_pkg::OP_WRITE: begin
                if (p < 5'd24) begin
                    d = write_bit(sh[3'd7 - q], s[1:0], scl, sda);
                end else if (p == 5'd24) begin
                    d = 2'b00;
                end else begin
                    d = {1'b1, sda};
                end
            end
            i2cm_pkg::OP_READ: begin
                if (p < 5'd16) begin
                    d = p[0] ? {1'b1, sda} : 2'b00;
                end else if (p < 5'd19) begin
                    d = write_bit(~ah, 2'(p - 5'd16), scl, sda);
                end
            end
            default: d = {scl, sda};
        endcase
        return d;
    endfunction

    assign o_pop = !i_q_status.empty && (!o_out_valid || !i_out_stall);

    // Phase length limit in ticks minus one, clipped to the prescaler range.
    assign w_eff_m1 = (i_cfg_data == '0) ? '0 : CW'(i_cfg_data - PTW'(1));
    assign w_cap_m1 = CW'({PRESCALE_WIDTH{1'b1}});
    assign w_limit  = (w_eff_m1 > w_cap_m1) ? w_cap_m1 : w_eff_m1;
    assign w_phase_nx = r_phase + 5'd1;

    always_comb begin
        n_op        = r_op;
        n_phase     = r_phase;
        n_pre       = r_pre;
        n_shift     = r_shift;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack       = r_ack;
        n_read_hold = r_read_hold;
        n_ack_hold  = r_ack_hold;
        n_done      = 1'b0;
        if (r_op == i2cm_pkg::OP_IDLE) begin
            if (i_item.op != i2cm_pkg::OP_IDLE) begin
                n_op    = i_item.op;
                n_phase = 5'd0;
                n_pre   = '0;
                if (i_item.op == i2cm_pkg::OP_WRITE) begin
                    n_shift = i_item.write_data;
                end
                if (i_item.op == i2cm_pkg::OP_READ) begin
                    n_shift    = 8'd0;
                    n_ack_hold = i_item.send_ack;
                end
                {n_scl, n_sda} = enter_phase(i_item.op, 5'd0, n_shift, n_ack_hold,
                                             r_scl, r_sda);
            end
        end else if (r_pre >= r_limit) begin
            if (r_op == i2cm_pkg::OP_WRITE && r_phase == 5'd24) begin
                n_ack = ~i_item.sda_in;
            end else if (r_op == i2cm_pkg::OP_READ && r_phase < 5'd16 && !r_phase[0]) begin
                n_shift = {r_shift[6:0], i_item.sda_in};
                if (r_phase == 5'd14) begin
                    n_read_hold = n_shift;
                end
            end
            n_pre = '0;
            if (w_phase_nx >= phase_total(r_op)) begin
                n_op    = i2cm_pkg::OP_IDLE;
                n_phase = 5'd0;
                n_done  = 1'b1;
            end else begin
                n_phase = w_phase_nx;
                {n_scl, n_sda} = enter_phase(r_op, w_phase_nx, n_shift, r_ack_hold,
                                             r_scl, r_sda);
            end
        end else begin
            n_pre = r_pre + PRESCALE_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op           <= i2cm_pkg::OP_IDLE;
            r_phase        <= 5'd0;
            r_pre          <= '0;
            r_limit        <= '0;
            r_shift        <= 8'd0;
            r_scl          <= 1'b0;
            r_sda          <= 1'b0;
            r_ack          <= 1'b0;
            r_read_hold    <= 8'd0;
            r_ack_hold     <= 1'b0;
            o_out_valid    <= 1'b0;
            o_scl_low      <= 1'b0;
            o_sda_low      <= 1'b0;
            o_busy_res     <= 1'b0;
            o_done_res     <= 1'b0;
            o_read_data    <= 8'd0;
            o_ack_received <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= w_limit[PRESCALE_WIDTH-1:0];
            end
            if (o_pop) begin
                r_op           <= n_op;
                r_phase        <= n_phase;
                r_pre          <= n_pre;
                r_shift        <= n_shift;
                r_scl          <= n_scl;
                r_sda          <= n_sda;
                r_ack          <= n_ack;
                r_read_hold    <= n_read_hold;
                r_ack_hold     <= n_ack_hold;
                o_out_valid    <= 1'b1;
                o_scl_low      <= n_scl;
                o_sda_low      <= n_sda;
                o_busy_res     <= (n_op != i2cm_pkg::OP_IDLE);
                o_done_res     <= n_done;
                o_read_data    <= n_read_hold;
                o_ack_received <= n_ack;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule
